// ===== design/kcl_pkg.sv =====
// ----------------------------------------------------------------------------
// kcl_pkg: keypad code lock shared definitions
// Field widths, message codes, register map and reset values.
// ----------------------------------------------------------------------------
package kcl_pkg;

  localparam int unsigned CodeDigitsDef = 4;

  localparam int unsigned SensorW = 10;
  localparam int unsigned SwitchW = 8;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned MsgW    = 3;
  localparam int unsigned PosW    = 2;

  localparam logic [SensorW-1:0] ThreshRst = 10'd600;
  localparam logic [SwitchW-1:0] BothEnds  = 8'h81;

  // message codes
  localparam logic [MsgW-1:0] MsgNone    = 3'd0;
  localparam logic [MsgW-1:0] MsgPrompt  = 3'd1;
  localparam logic [MsgW-1:0] MsgEcho    = 3'd2;
  localparam logic [MsgW-1:0] MsgCorrect = 3'd3;
  localparam logic [MsgW-1:0] MsgWrong   = 3'd4;
  localparam logic [MsgW-1:0] MsgChanged = 3'd5;

  // register map: one 32-bit register at word index 0
  localparam int unsigned PaddrW    = 3;
  localparam int unsigned PdataW    = 32;
  localparam logic        RegThresh = 1'b0;

  typedef struct packed {
    logic [SensorW-1:0] sensor_a;
    logic [SensorW-1:0] sensor_b;
    logic [SwitchW-1:0] switch_lines;
    logic [DigitW-1:0]  key_code;
  } item_t;

  typedef struct packed {
    logic              door_open;
    logic [MsgW-1:0]   message;
    logic [PosW-1:0]   echo_position;
    logic [DigitW-1:0] echo_digit;
  } result_t;

endpackage

// ===== design/kcl_ifs.sv =====
// ----------------------------------------------------------------------------
// kcl_ifs: keypad code lock channel interfaces
// Valid/ready channels for polling passes and result items.
// ----------------------------------------------------------------------------
interface kcl_item_if;
  logic                              valid;
  logic                              ready;
  logic [kcl_pkg::SensorW-1:0] sensor_a;
  logic [kcl_pkg::SensorW-1:0] sensor_b;
  logic [kcl_pkg::SwitchW-1:0] switch_lines;
  logic [kcl_pkg::DigitW-1:0]  key_code;

  modport source (output valid, sensor_a, sensor_b, switch_lines, key_code, input ready);
  modport sink   (input valid, sensor_a, sensor_b, switch_lines, key_code, output ready);
endinterface

interface kcl_result_if;
  logic                             valid;
  logic                             ready;
  logic                             door_open;
  logic [kcl_pkg::MsgW-1:0]   message;
  logic [kcl_pkg::PosW-1:0]   echo_position;
  logic [kcl_pkg::DigitW-1:0] echo_digit;

  modport source (output valid, door_open, message, echo_position, echo_digit, input ready);
  modport sink   (input valid, door_open, message, echo_position, echo_digit, output ready);
endinterface

// ===== design/kcl_cfg.sv =====
// ----------------------------------------------------------------------------
// kcl_cfg: configuration register port
// APB-style access to the presence threshold register.
// ----------------------------------------------------------------------------
module kcl_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kcl_pkg::PaddrW-1:0]    paddr,
  input  logic [kcl_pkg::PdataW-1:0]    pwdata,
  output logic [kcl_pkg::PdataW-1:0]    prdata,
  output logic                          pready,
  output logic [kcl_pkg::SensorW-1:0]   threshold_o
);
  import kcl_pkg::*;

  logic [SensorW-1:0] thresh_q;
  logic               sel_thresh;
  logic               wr_en;

  assign sel_thresh = (paddr[PaddrW-1:2] == RegThresh);
  assign wr_en      = psel && penable && pwrite && pready;
  assign pready     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshRst;
    end else if (wr_en && sel_thresh) begin
      thresh_q <= pwdata[SensorW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_thresh) begin
      prdata = PdataW'(thresh_q);
    end
  end

  assign threshold_o = thresh_q;

endmodule

// ===== design/kcl_seq.sv =====
// ----------------------------------------------------------------------------
// kcl_seq: lock sequencer
// Phase register, code stores and the per-pass result logic.
// ----------------------------------------------------------------------------
module kcl_seq #(
  parameter int unsigned CodeDigits = kcl_pkg::CodeDigitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  kcl_pkg::item_t              item_i,
  input  logic [kcl_pkg::SensorW-1:0] threshold_i,
  output kcl_pkg::result_t            result_o
);
  import kcl_pkg::*;

  localparam int unsigned IdxW = $clog2(CodeDigits + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CodeDigits - 1);
  localparam logic [IdxW-1:0] NumDig  = IdxW'(CodeDigits);

  typedef enum logic [6:0] {
    PhIdle    = 7'b0000001,
    PhPrompt  = 7'b0000010,
    PhSet     = 7'b0000100,
    PhFirst   = 7'b0001000,
    PhCollect = 7'b0010000,
    PhCheck   = 7'b0100000,
    PhOpen    = 7'b1000000
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [IdxW-1:0]   set_q, set_d;
  logic [IdxW-1:0]   entry_q, entry_d;
  logic [DigitW-1:0] stored_q  [CodeDigits];
  logic [DigitW-1:0] entered_q [CodeDigits];

  logic              stored_we;
  logic              entered_we;
  logic [IdxW-1:0]   entered_idx;
  logic              sw_onehot;
  logic              match;
  result_t           res;

  assign sw_onehot = (item_i.switch_lines != '0) &&
                     ((item_i.switch_lines & (item_i.switch_lines - 8'd1)) == '0);

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CodeDigits; i++) begin
      if (entered_q[i] != stored_q[i]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    phase_d     = phase_q;
    set_d       = set_q;
    entry_d     = entry_q;
    stored_we   = 1'b0;
    entered_we  = 1'b0;
    entered_idx = entry_q;
    res         = '0;
    case (phase_q)
      PhIdle: begin
        if (item_i.sensor_a > threshold_i || item_i.sensor_b > threshold_i) begin
          phase_d = PhPrompt;
        end
      end
      PhPrompt: begin
        res.message = MsgPrompt;
        if ((item_i.switch_lines & BothEnds) == BothEnds) begin
          set_d   = '0;
          phase_d = PhSet;
        end else if (sw_onehot) begin
          entered_we  = 1'b1;
          entered_idx = '0;
          phase_d     = PhFirst;
        end
      end
      PhSet: begin
        if (sw_onehot) begin
          stored_we = 1'b1;
          if (set_q >= LastIdx) begin
            res.message = MsgChanged;
            set_d       = '0;
            phase_d     = PhPrompt;
          end else begin
            res.message       = MsgEcho;
            res.echo_position = PosW'(set_q);
            res.echo_digit    = item_i.key_code;
            set_d             = set_q + IdxW'(1);
          end
        end
      end
      PhFirst: begin
        res.message    = MsgEcho;
        res.echo_digit = entered_q[0];
        if (CodeDigits <= 1) begin
          phase_d = PhCheck;
        end else begin
          entry_d = IdxW'(1);
          phase_d = PhCollect;
        end
      end
      PhCollect: begin
        if (entry_q >= NumDig) begin
          phase_d = PhCheck;
        end else if (sw_onehot) begin
          entered_we        = 1'b1;
          res.message       = MsgEcho;
          res.echo_position = PosW'(entry_q);
          res.echo_digit    = item_i.key_code;
          entry_d           = entry_q + IdxW'(1);
          if (entry_q >= LastIdx) begin
            phase_d = PhCheck;
          end
        end
      end
      PhCheck: begin
        if (match) begin
          res.message = MsgCorrect;
          phase_d     = PhOpen;
        end else begin
          res.message = MsgWrong;
          phase_d     = PhPrompt;
        end
      end
      PhOpen: begin
        res.door_open = 1'b1;
        phase_d       = PhIdle;
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      set_q   <= '0;
      entry_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      set_q   <= set_d;
      entry_q <= entry_d;
    end
  end

  for (genvar g = 0; g < CodeDigits; g++) begin : g_digit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stored_q[g]  <= DigitW'((g % 8) + 1);
        entered_q[g] <= '0;
      end else if (step_i) begin
        if (stored_we && set_q == IdxW'(g)) begin
          stored_q[g] <= item_i.key_code;
        end
        if (entered_we && entered_idx == IdxW'(g)) begin
          entered_q[g] <= item_i.key_code;
        end
      end
    end
  end

  assign result_o = res;

endmodule

// ===== design/keypad_code_lock_controller.sv =====
// ----------------------------------------------------------------------------
// keypad_code_lock_controller: four-digit keypad lock
// Input register, lock sequencer and result register behind valid/ready
// channels, with an APB-style port for the presence threshold.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  item_i    | in        | sensor_a, sensor_b, switch_lines, key_code
//  result_o  | out       | door_open, message, echo_position, echo_digit
//  apb       | in/out    | presence_threshold at byte address 0
//
// One polling pass per clock while the result is not stalled: a request lands
// in the input register, the sequencer evaluates it combinationally and
// writes the result register; a result is valid once it is held there.
// A stalled result holds the sequencer; the input register still takes one
// more request, so ready drops only when both registers are full.
// Reset clears the phase, indexes and entered code; stored code is 1,2,3,4.
// ----------------------------------------------------------------------------
module keypad_code_lock_controller #(
  parameter int unsigned CodeDigits = kcl_pkg::CodeDigitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  kcl_item_if.sink                   item_i,
  kcl_result_if.source               result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kcl_pkg::PaddrW-1:0] paddr,
  input  logic [kcl_pkg::PdataW-1:0] pwdata,
  output logic [kcl_pkg::PdataW-1:0] prdata,
  output logic                       pready
);
  import kcl_pkg::*;

  logic               in_vld_q;
  item_t              in_q;
  logic               out_vld_q;
  result_t            out_q;
  result_t            seq_res;
  logic               step;
  logic [SensorW-1:0] threshold;

  kcl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .threshold_o (threshold)
  );

  // advance only when the result register is free or being drained
  assign step         = in_vld_q && (!out_vld_q || result_o.ready);
  assign item_i.ready = !in_vld_q || step;

  kcl_seq #(
    .CodeDigits (CodeDigits)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_q),
    .threshold_i (threshold),
    .result_o    (seq_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (item_i.valid && item_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      in_q.sensor_a     <= item_i.sensor_a;
      in_q.sensor_b     <= item_i.sensor_b;
      in_q.switch_lines <= item_i.switch_lines;
      in_q.key_code     <= item_i.key_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= seq_res;
    end
  end

  assign result_o.valid         = out_vld_q;
  assign result_o.door_open     = out_q.door_open;
  assign result_o.message       = out_q.message;
  assign result_o.echo_position = out_q.echo_position;
  assign result_o.echo_digit    = out_q.echo_digit;

endmodule
